### hw/rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int UnitW = 13;
	localparam int AddrW = 12;
	localparam int UsedW = 17;
	localparam int CntW  = 12;
	localparam int NeedW = 29;

	localparam logic [UnitW-1:0] MaxUnits = 13'd4096;
	localparam logic [UnitW-1:0] MinUnits = 13'd2;

	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_UNITS = 2'd1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_OOM   = 2'd2,
		ST_RANGE = 2'd3
	} st_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_LOAD,
		OP_EVAL,
		OP_SPLIT,
		OP_TAKE,
		OP_SUB,
		OP_BSET,
		OP_REL,
		OP_NMERGE,
		OP_PMERGE,
		OP_FIX
	} op_t;

	typedef enum logic [1:0] {
		RD_I,
		RD_N,
		RD_P
	} rd_sel_t;

	typedef struct packed {
		op_t     op;
		rd_sel_t rd_sel;
		logic    step;
		logic    set_st;
		st_t     st;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic zero_req;
		logic walk_end;
		logic sz_zero;
		logic fits;
		logic split;
		logic hit;
		logic past;
		logic busy;
		logic n_ok;
		logic p_ok;
		logic null_addr;
		logic range_err;
		logic bad_ptr;
	} sts_t;

endpackage

### hw/rtl/ffha_ctrl.sv
module ffha_ctrl
	import ffha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [18:0] {
		S_INIT   = 19'h00001,
		S_IDLE   = 19'h00002,
		S_DISP   = 19'h00004,
		S_ARD    = 19'h00008,
		S_AEV    = 19'h00010,
		S_ASPLIT = 19'h00020,
		S_ATAKE  = 19'h00040,
		S_FSUB   = 19'h00080,
		S_FCHK   = 19'h00100,
		S_FRD    = 19'h00200,
		S_FEV    = 19'h00400,
		S_FREL   = 19'h00800,
		S_FNRD   = 19'h01000,
		S_FNEV   = 19'h02000,
		S_FNFIX  = 19'h04000,
		S_FPCHK  = 19'h08000,
		S_FPEV   = 19'h10000,
		S_FPFIX  = 19'h20000,
		S_DONE   = 19'h40000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		cmd.rd_sel = RD_I;
		cmd.step   = 1'b0;
		cmd.set_st = 1'b0;
		cmd.st     = ST_OK;
		case (state_q)
			S_INIT: begin
				cmd.op  = OP_INIT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.is_free) begin
					state_d = S_FSUB;
				end else if (sts.zero_req) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_ZERO;
					state_d    = S_DONE;
				end else begin
					state_d = S_ARD;
				end
			end
			S_ARD: state_d = S_AEV;
			S_AEV: begin
				cmd.op = OP_EVAL;
				if (sts.walk_end || sts.sz_zero) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_OOM;
					state_d    = S_DONE;
				end else if (sts.fits) begin
					state_d = sts.split ? S_ASPLIT : S_ATAKE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_ARD;
				end
			end
			S_ASPLIT: begin
				cmd.op  = OP_SPLIT;
				state_d = S_ATAKE;
			end
			S_ATAKE: begin
				cmd.op     = OP_TAKE;
				cmd.set_st = 1'b1;
				state_d    = S_DONE;
			end
			S_FSUB: begin
				cmd.op  = OP_SUB;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				cmd.op = OP_BSET;
				if (sts.null_addr) begin
					cmd.set_st = 1'b1;
					state_d    = S_DONE;
				end else if (sts.range_err) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_RANGE;
					state_d    = S_DONE;
				end else if (sts.bad_ptr) begin
					cmd.set_st = 1'b1;
					state_d    = S_DONE;
				end else begin
					state_d = S_FRD;
				end
			end
			S_FRD: state_d = S_FEV;
			S_FEV: begin
				cmd.op = OP_EVAL;
				if (sts.walk_end) begin
					cmd.set_st = 1'b1;
					state_d    = S_DONE;
				end else if (sts.hit) begin
					if (sts.busy) begin
						state_d = S_FREL;
					end else begin
						cmd.set_st = 1'b1;
						state_d    = S_DONE;
					end
				end else if (sts.past || sts.sz_zero) begin
					cmd.set_st = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_FRD;
				end
			end
			S_FREL: begin
				cmd.op  = OP_REL;
				state_d = S_FNRD;
			end
			S_FNRD: begin
				cmd.rd_sel = RD_N;
				state_d    = sts.n_ok ? S_FNEV : S_FPCHK;
			end
			S_FNEV: begin
				if (sts.busy) begin
					state_d = S_FPCHK;
				end else begin
					cmd.op  = OP_NMERGE;
					state_d = S_FNFIX;
				end
			end
			S_FNFIX: begin
				cmd.op  = OP_FIX;
				state_d = S_FPCHK;
			end
			S_FPCHK: begin
				cmd.rd_sel = RD_P;
				if (sts.p_ok) begin
					state_d = S_FPEV;
				end else begin
					cmd.set_st = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_FPEV: begin
				if (sts.busy) begin
					cmd.set_st = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.op  = OP_PMERGE;
					state_d = S_FPFIX;
				end
			end
			S_FPFIX: begin
				cmd.op     = OP_FIX;
				cmd.set_st = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

endmodule

### hw/rtl/ffha_dp.sv
module ffha_dp
	import ffha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        func,
	input  logic [31:0] request_bytes,
	input  logic [63:0] free_address,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic [63:0] pointer,
	output logic [1:0]  status,
	output logic [UsedW-1:0] used_bytes,
	output logic [CntW-1:0]  block_count
);

	// header split over two arrays: {busy, size} and previous size
	logic [UnitW:0]   sb_mem [0:MaxUnits-1];
	logic [UnitW-1:0] pv_mem [0:MaxUnits-1];

	logic [63:0]      base_q;
	logic [UnitW-1:0] units_q;
	logic [UsedW-1:0] used_q;
	logic [CntW-1:0]  blocks_q;
	logic             func_q, zero_q, borrow_q;
	logic [NeedW-1:0] need_q;
	logic [63:0]      addr_q, off_q, ptr_q;
	st_t              st_q;
	logic [UnitW:0]   i_q;
	logic [UnitW-1:0] b_q, cur_sz_q, cur_pv_q, msz_q;
	logic [UnitW:0]   rd_sb_q;
	logic [UnitW-1:0] rd_pv_q;

	logic [UnitW-1:0] rd_sz;
	logic [UnitW:0]   n_sum, a_fix, a_take;
	logic [UnitW-1:0] p_idx, tsz, merged, cfg_units;
	logic [UnitW:0]   t_idx;
	logic             take_split;
	logic [AddrW-1:0] rd_addr;

	logic             sb_we, pv_we;
	logic [AddrW-1:0] sb_wa, pv_wa;
	logic [UnitW:0]   sb_wd;
	logic [UnitW-1:0] pv_wd;

	assign rd_sz      = rd_sb_q[UnitW-1:0];
	assign n_sum      = {1'b0, b_q} + {1'b0, msz_q};
	assign a_fix      = n_sum;
	assign p_idx      = b_q - cur_pv_q;
	assign t_idx      = i_q + {1'b0, need_q[UnitW-1:0]};
	assign a_take     = i_q + {1'b0, cur_sz_q};
	assign take_split = {{(NeedW-UnitW){1'b0}}, cur_sz_q} >= need_q + NeedW'(2);
	assign tsz        = take_split ? need_q[UnitW-1:0] : cur_sz_q;
	assign merged     = (cmd.op == OP_PMERGE) ? rd_sz + msz_q : msz_q + rd_sz;

	always_comb begin
		cfg_units = cfg_data[UnitW-1:0];
		if (cfg_units < MinUnits) cfg_units = MinUnits;
		else if (cfg_units > MaxUnits) cfg_units = MaxUnits;
	end

	always_comb begin
		sts.is_free   = func_q;
		sts.zero_req  = zero_q;
		sts.walk_end  = i_q >= {1'b0, units_q};
		sts.sz_zero   = (rd_sz == '0);
		sts.fits      = !rd_sb_q[UnitW] && ({{(NeedW-UnitW){1'b0}}, rd_sz} >= need_q);
		sts.split     = {{(NeedW-UnitW){1'b0}}, rd_sz} >= need_q + NeedW'(2);
		sts.hit       = (i_q == {1'b0, b_q});
		sts.past      = (i_q > {1'b0, b_q});
		sts.busy      = rd_sb_q[UnitW];
		sts.n_ok      = n_sum < {1'b0, units_q};
		sts.p_ok      = (cur_pv_q != '0) && (cur_pv_q <= b_q);
		sts.null_addr = (addr_q == '0);
		sts.range_err = borrow_q || (off_q[63:17] != '0) ||
			(off_q[16:0] >= {units_q, 4'b0});
		sts.bad_ptr   = (off_q[3:0] != '0) || (off_q[16:4] == '0);
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_N:    rd_addr = n_sum[AddrW-1:0];
			RD_P:    rd_addr = p_idx[AddrW-1:0];
			default: rd_addr = i_q[AddrW-1:0];
		endcase
	end

	always_comb begin
		sb_we = 1'b0;
		sb_wa = '0;
		sb_wd = '0;
		pv_we = 1'b0;
		pv_wa = '0;
		pv_wd = '0;
		if (cfg_we && cfg_index == REG_UNITS) begin
			sb_we = 1'b1;
			sb_wd = {1'b0, cfg_units};
			pv_we = 1'b1;
		end else begin
			case (cmd.op)
				OP_INIT: begin
					sb_we = 1'b1;
					sb_wd = {1'b0, units_q};
					pv_we = 1'b1;
				end
				OP_SPLIT: begin
					sb_we = 1'b1;
					sb_wa = t_idx[AddrW-1:0];
					sb_wd = {1'b0, cur_sz_q - need_q[UnitW-1:0]};
					pv_we = 1'b1;
					pv_wa = t_idx[AddrW-1:0];
					pv_wd = need_q[UnitW-1:0];
				end
				OP_TAKE: begin
					sb_we = 1'b1;
					sb_wa = i_q[AddrW-1:0];
					sb_wd = {1'b1, tsz};
					pv_we = take_split && (a_take < {1'b0, units_q});
					pv_wa = a_take[AddrW-1:0];
					pv_wd = cur_sz_q - need_q[UnitW-1:0];
				end
				OP_REL: begin
					sb_we = 1'b1;
					sb_wa = b_q[AddrW-1:0];
					sb_wd = {1'b0, cur_sz_q};
				end
				OP_NMERGE: begin
					sb_we = 1'b1;
					sb_wa = b_q[AddrW-1:0];
					sb_wd = {1'b0, merged};
				end
				OP_PMERGE: begin
					sb_we = 1'b1;
					sb_wa = p_idx[AddrW-1:0];
					sb_wd = {1'b0, merged};
				end
				OP_FIX: begin
					pv_we = a_fix < {1'b0, units_q};
					pv_wa = a_fix[AddrW-1:0];
					pv_wd = msz_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sb_we) sb_mem[sb_wa] <= sb_wd;
		rd_sb_q <= sb_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pv_we) pv_mem[pv_wa] <= pv_wd;
		rd_pv_q <= pv_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			units_q  <= MaxUnits;
			used_q   <= '0;
			blocks_q <= CntW'(1);
			func_q   <= 1'b0;
			zero_q   <= 1'b0;
			st_q     <= ST_OK;
		end else begin
			if (cfg_we && cfg_index == REG_BASE) base_q <= cfg_data;
			if (cfg_we && cfg_index == REG_UNITS) begin
				units_q  <= cfg_units;
				used_q   <= '0;
				blocks_q <= CntW'(1);
			end else begin
				case (cmd.op)
					OP_INIT: begin
						used_q   <= '0;
						blocks_q <= CntW'(1);
					end
					OP_TAKE: begin
						used_q <= used_q + {tsz - UnitW'(1), 4'b0};
						if (take_split) blocks_q <= blocks_q + CntW'(1);
					end
					OP_REL:    used_q <= used_q - {cur_sz_q - UnitW'(1), 4'b0};
					OP_NMERGE: blocks_q <= blocks_q - CntW'(1);
					OP_PMERGE: blocks_q <= blocks_q - CntW'(1);
					default: ;
				endcase
			end
			if (cmd.op == OP_LOAD) begin
				func_q <= func;
				zero_q <= (request_bytes == '0);
			end
			if (cmd.set_st) st_q <= cmd.st;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				need_q <= {1'b0, request_bytes[31:4]} +
					NeedW'(request_bytes[3:0] != '0) + NeedW'(1);
				addr_q <= free_address;
				ptr_q  <= '0;
				i_q    <= '0;
			end
			OP_EVAL: begin
				cur_sz_q <= rd_sz;
				cur_pv_q <= rd_pv_q;
			end
			OP_TAKE: ptr_q <= base_q + {47'b0, i_q[UnitW-1:0] + UnitW'(1), 4'b0};
			OP_SUB:  {borrow_q, off_q} <= {1'b0, addr_q} - {1'b0, base_q};
			OP_BSET: b_q <= off_q[16:4] - UnitW'(1);
			OP_REL:  msz_q <= cur_sz_q;
			OP_NMERGE: msz_q <= merged;
			OP_PMERGE: begin
				msz_q <= merged;
				b_q   <= p_idx;
			end
			default: ;
		endcase
		if (cmd.step) i_q <= i_q + {1'b0, rd_sz};
	end

	assign pointer     = ptr_q;
	assign status      = st_q;
	assign used_bytes  = used_q;
	assign block_count = blocks_q;

`ifndef SYNTH
	logic units_wr;
	assign units_wr = cfg_we && (cfg_index == REG_UNITS);

	a_take_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_TAKE && !units_wr) |=> (used_q != $past(used_q)))
		else $error("allocation left used byte count unchanged");

	a_merge_drops: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_NMERGE || cmd.op == OP_PMERGE) && !units_wr)
		|=> (blocks_q == $past(blocks_q) - CntW'(1)))
		else $error("merge did not reduce block count");

	a_split_adds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_TAKE && take_split && !units_wr)
		|=> (blocks_q == $past(blocks_q) + CntW'(1)))
		else $error("split did not add a block");
`endif

endmodule

### hw/rtl/first_fit_heap_allocator.sv
// An allocate walks the block headers from unit 0 until one fits or the walk ends;
// a free checks the address, walks the headers up to the named block, then merges.
// One item at a time: a new item is taken only in idle, once the last result is taken;
// the walk reads each header through the registered read port of the header arrays.
// Reset: one cycle formats unit 0 as a single free block before in_ready rises.
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] request_bytes,
	input  logic [63:0] free_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] pointer,
	output logic [1:0]  status,
	output logic [16:0] used_bytes,
	output logic [11:0] block_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffha_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.request_bytes (request_bytes),
		.free_address  (free_address),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pointer       (pointer),
		.status        (status),
		.used_bytes    (used_bytes),
		.block_count   (block_count)
	);

endmodule

### sim/first_fit_heap_allocator_test.sv
module first_fit_heap_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ffha_pkg::*;

	localparam int HeapMax = 4096;
	localparam longint CycleLimit = 3000000;
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	typedef struct {
		logic [63:0] pointer;
		st_t         status;
		logic [16:0] used;
		logic [11:0] blocks;
	} heap_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [31:0] request_bytes;
	logic [63:0] free_address;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] pointer;
	logic [1:0]  status;
	logic [16:0] used_bytes;
	logic [11:0] block_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	first_fit_heap_allocator DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// local copy of the heap
	int          hdr_size [HeapMax];
	int          hdr_prev [HeapMax];
	bit          hdr_busy [HeapMax];
	logic [63:0] heap_base;
	int          heap_units;
	int          used_total;
	int          blocks_total;

	heap_result_t pending_results[$];
	logic [63:0]  live_ptrs[$];
	int           errors = 0;
	longint       cycles = 0;
	bit           idling_on = 1'b1;
	int           out_stall = 0;

	function automatic int clamp_units(int v);
		if (v < 2)
			return 2;
		if (v > HeapMax)
			return HeapMax;
		return v;
	endfunction

	function automatic void format_heap();
		hdr_size[0] = heap_units;
		hdr_prev[0] = 0;
		hdr_busy[0] = 1'b0;
		used_total = 0;
		blocks_total = 1;
	endfunction

	function automatic bit is_block_head(longint unsigned u);
		longint unsigned i = 0;
		while (i < heap_units) begin
			if (i == u)
				return 1'b1;
			if (i > u || hdr_size[i] == 0)
				return 1'b0;
			i += hdr_size[i];
		end
		return 1'b0;
	endfunction

	function automatic st_t alloc_block(logic [31:0] req, output logic [63:0] ptr);
		longint unsigned need;
		longint unsigned i = 0;
		longint unsigned t;
		longint unsigned a;
		int sz;
		ptr = '0;
		if (req == 0)
			return ST_ZERO;
		need = (longint'(req) + 15) / 16 + 1;
		if (need < 2)
			need = 2;
		while (i < heap_units) begin
			sz = hdr_size[i];
			if (sz == 0)
				break;
			if (!hdr_busy[i] && sz >= need) begin
				if (sz >= need + 2) begin
					t = i + need;
					hdr_size[t] = sz - int'(need);
					hdr_prev[t] = int'(need);
					hdr_busy[t] = 1'b0;
					hdr_size[i] = int'(need);
					a = t + hdr_size[t];
					if (a < heap_units)
						hdr_prev[a] = hdr_size[t];
					blocks_total++;
				end
				hdr_busy[i] = 1'b1;
				used_total += (hdr_size[i] - 1) * 16;
				ptr = heap_base + 64'(i) * 16 + 16;
				return ST_OK;
			end
			i += sz;
		end
		return ST_OOM;
	endfunction

	function automatic st_t release_block(logic [63:0] addr);
		logic [63:0] off;
		longint unsigned b;
		longint unsigned n;
		longint unsigned a;
		longint unsigned p;
		if (addr == 0)
			return ST_OK;
		if (addr < heap_base)
			return ST_RANGE;
		off = addr - heap_base;
		if (off >= 64'(heap_units) * 16)
			return ST_RANGE;
		if (off[3:0] != 0 || off < 16)
			return ST_OK;
		b = off / 16 - 1;
		if (!is_block_head(b) || !hdr_busy[b])
			return ST_OK;
		hdr_busy[b] = 1'b0;
		used_total -= (hdr_size[b] - 1) * 16;
		n = b + hdr_size[b];
		if (n < heap_units && !hdr_busy[n]) begin
			hdr_size[b] += hdr_size[n];
			blocks_total--;
			a = b + hdr_size[b];
			if (a < heap_units)
				hdr_prev[a] = hdr_size[b];
		end
		if (hdr_prev[b] != 0 && hdr_prev[b] <= b) begin
			p = b - hdr_prev[b];
			if (!hdr_busy[p]) begin
				hdr_size[p] += hdr_size[b];
				blocks_total--;
				a = p + hdr_size[p];
				if (a < heap_units)
					hdr_prev[a] = hdr_size[p];
			end
		end
		return ST_OK;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling_on || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called on a rising edge; returns on a rising edge
	task automatic send_item(logic fn, logic [31:0] req, logic [63:0] addr,
			output heap_result_t res);
		int gap;
		in_valid <= 1'b1;
		func <= fn;
		request_bytes <= req;
		free_address <= addr;
		do
			@(posedge clk);
		while (!in_ready);
		if (fn == FN_ALLOC)
			res.status = alloc_block(req, res.pointer);
		else begin
			res.status = release_block(addr);
			res.pointer = '0;
		end
		res.used = 17'(used_total);
		res.blocks = 12'(blocks_total);
		pending_results.push_back(res);
		if (fn == FN_ALLOC && res.status == ST_OK)
			live_ptrs.push_back(res.pointer);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic do_alloc(logic [31:0] req);
		heap_result_t r;
		send_item(FN_ALLOC, req, $urandom(), r);
	endtask

	task automatic do_free(logic [63:0] addr);
		heap_result_t r;
		send_item(FN_FREE, $urandom(), addr, r);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_BASE)
			heap_base = data;
		else if (idx == REG_UNITS) begin
			heap_units = clamp_units(int'(data[12:0]));
			format_heap();
			live_ptrs.delete();
		end
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		heap_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (pointer !== e.pointer) begin
					$error("pointer: expected %h, got %h", e.pointer, pointer);
					errors++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					errors++;
				end
				if (used_bytes !== e.used) begin
					$error("used_bytes: expected %0d, got %0d", e.used, used_bytes);
					errors++;
				end
				if (block_count !== e.blocks) begin
					$error("block_count: expected %0d, got %0d", e.blocks, block_count);
					errors++;
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idling_on && $urandom_range(0, 5) == 0)
				out_stall <= pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("first_fit_heap_allocator verification failed");
			$finish;
		end
	end

	task automatic test_reset_heap();
		heap_result_t a;
		heap_result_t b;
		heap_result_t c;
		do_alloc(32'd0);
		do_alloc(32'hFFFF_FFFF);
		do_alloc(32'd65521);
		send_item(FN_ALLOC, 32'd1, '0, a);
		send_item(FN_ALLOC, 32'd16, '0, b);
		send_item(FN_ALLOC, 32'd17, '0, c);
		do_free(64'd0);
		do_free(64'd65536);
		do_free(64'hFFFF_FFFF_FFFF_FFFF);
		do_free(b.pointer + 8);
		do_free(b.pointer + 16);
		do_free(64'd65520);
		do_free(b.pointer);
		do_free(b.pointer);
		do_free(a.pointer);
		do_free(c.pointer);
		do_alloc(32'd65520);
		wait_idle();
	endtask

	task automatic test_region_limits();
		heap_result_t a;
		cfg_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
		cfg_write(REG_UNITS, 64'd0);
		do_alloc(32'd17);
		send_item(FN_ALLOC, 32'd16, '0, a);
		do_alloc(32'd1);
		do_free(64'hFFFF_FFFF_FFFF_FFE0);
		do_free(64'hFFFF_FFFF_FFFF_FFF0);
		do_free(a.pointer);
		wait_idle();
		cfg_write(REG_BASE, 64'h0000_0000_8000_0000);
		cfg_write(REG_UNITS, 64'd1);
		do_free(64'h0000_0000_8000_0000);
		do_free(64'h0000_0000_7FFF_FFF0);
		wait_idle();
		cfg_write(REG_UNITS, 64'h1FFF);
		do_alloc(32'd65520);
		do_free(64'h0000_0000_8000_0010);
		wait_idle();
		cfg_write(REG_UNITS, 64'd4096);
	endtask

	task automatic test_random_traffic();
		int n_items;
		int k;
		int r;
		logic [63:0] addr;
		for (int phase = 0; phase < 6; phase++) begin
			idling_on = (phase % 3) != 1;
			cfg_write(REG_BASE, {$urandom(), $urandom_range(0, 15) == 0 ? $urandom()
				: ($urandom() & 32'hFFFF_FFF0)});
			r = $urandom_range(0, 9);
			if (r == 0)
				cfg_write(REG_UNITS, 64'd4096);
			else if (r == 1)
				cfg_write(REG_UNITS, 64'($urandom_range(0, 8191)));
			else
				cfg_write(REG_UNITS, 64'($urandom_range(2, 300)));
			n_items = 95;
			for (int i = 0; i < n_items; i++) begin
				r = $urandom_range(0, 99);
				if (r < 52) begin
					k = $urandom_range(0, 19);
					if (k == 0)
						do_alloc(32'd0);
					else if (k == 1)
						do_alloc($urandom());
					else if (k < 5)
						do_alloc($urandom_range(1, 4000));
					else
						do_alloc($urandom_range(1, 200));
				end else if (r < 88 && live_ptrs.size() != 0) begin
					k = $urandom_range(0, live_ptrs.size() - 1);
					addr = live_ptrs[k];
					live_ptrs.delete(k);
					do_free(addr);
				end else begin
					k = $urandom_range(0, 5);
					case (k)
						0: addr = {$urandom(), $urandom()};
						1: addr = heap_base + 64'($urandom_range(0, heap_units * 16 + 64));
						2: addr = heap_base + 64'($urandom_range(0, heap_units)) * 16;
						3: addr = heap_base - 64'($urandom_range(1, 64));
						4: addr = '0;
						default: addr = live_ptrs.size() != 0 ? live_ptrs[0] + 16
							: heap_base + 16;
					endcase
					do_free(addr);
				end
			end
			wait_idle();
		end
		idling_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FN_ALLOC;
		request_bytes = '0;
		free_address = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE;
		cfg_data = '0;
		for (int i = 0; i < HeapMax; i++) begin
			hdr_size[i] = 0;
			hdr_prev[i] = 0;
			hdr_busy[i] = 1'b0;
		end
		heap_base = '0;
		heap_units = HeapMax;
		format_heap();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_heap();
		test_region_limits();
		test_random_traffic();

		wait_idle();
		if (errors == 0)
			$display("first_fit_heap_allocator verification clean");
		else
			$display("first_fit_heap_allocator verification failed");
		$finish;
	end

endmodule
